>>> hdl/nrp_pkg.sv
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared constants, codes and record types for the nested region profiler.
// ----------------------------------------------------------------------------
package nrp_pkg;

  localparam int NUM_ANCHORS = 64;
  localparam int STACK_DEPTH = 32;

  localparam int ANCHOR_W = $clog2(NUM_ANCHORS);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int FIDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 6;
  localparam int TICK_W   = 64;
  localparam int HITS_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // one anchor table entry
  typedef struct packed {
    logic [TICK_W-1:0] excl;
    logic [TICK_W-1:0] incl;
    logic [HITS_W-1:0] hits;
  } anchor_entry_t;

  // one call stack frame
  typedef struct packed {
    logic [ANCHOR_W-1:0] parent;
    logic [ANCHOR_W-1:0] anchor;
    logic [TICK_W-1:0]   old_incl;
    logic [TICK_W-1:0]   start;
  } frame_t;

endpackage

>>> hdl/nested_region_profiler.sv
// Nested region profiler. Each transaction carries a begin, end, read or clear
// event and returns exactly one result through a registered output, so a new
// event can be taken while the previous result is still stalled. Events are
// handled one at a time. An end goes through the single read port of the anchor
// table, which must fetch and write back the parent entry and then the anchor
// entry in turn, after its frame is read from the call stack memory. A begin on
// a full stack or an end on an empty stack goes straight to the done state. A
// result waits to be loaded while the output stays stalled. Clear takes effect
// at once through per-entry valid bits; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// nested_region_profiler
// Inclusive and exclusive tick totals per anchor, kept in an anchor table
// memory and a call stack memory, both with registered read data.
// ----------------------------------------------------------------------------
module nested_region_profiler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nrp_pkg::FUNC_W-1:0]     func,
  input  logic [nrp_pkg::ID_W-1:0]       anchor_id,
  input  logic [nrp_pkg::TICK_W-1:0]     timestamp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nrp_pkg::STATUS_W-1:0]   status,
  output logic [nrp_pkg::TICK_W-1:0]     exclusive_ticks,
  output logic [nrp_pkg::TICK_W-1:0]     inclusive_ticks,
  output logic [nrp_pkg::HITS_W-1:0]     hits
);
  import nrp_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_BEGIN  = 8'b0000_0010,
    ST_FRAME  = 8'b0000_0100,
    ST_PARENT = 8'b0000_1000,
    ST_ANC_RD = 8'b0001_0000,
    ST_ANCHOR = 8'b0010_0000,
    ST_REPORT = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // memories
  anchor_entry_t tbl_mem [NUM_ANCHORS];
  frame_t        frm_mem [STACK_DEPTH];

  logic                tbl_rd, tbl_wr;
  logic [ANCHOR_W-1:0] tbl_rd_addr, tbl_wr_addr;
  anchor_entry_t       tbl_wr_data, tbl_rd_data;
  logic                tbl_rd_hit;
  logic                frm_rd, frm_wr;
  logic [FIDX_W-1:0]   frm_rd_addr, frm_wr_addr;
  frame_t              frm_wr_data, frm_rd_data;

  // control state
  logic [SP_W-1:0]        sp;
  logic [SP_W-1:0]        sp_dec;
  logic [ANCHOR_W-1:0]    cur_parent;
  logic [NUM_ANCHORS-1:0] ent_valid;

  // working registers of the current transaction
  logic [ANCHOR_W-1:0] op_slot;
  logic [TICK_W-1:0]   op_ts;
  logic [TICK_W-1:0]   elapsed;
  logic [ANCHOR_W-1:0] fr_parent;
  logic [ANCHOR_W-1:0] fr_anchor;
  logic [TICK_W-1:0]   fr_old_incl;
  logic [STATUS_W-1:0] res_status;
  anchor_entry_t       res_entry;

  logic          accept;
  logic          out_free;
  logic [ANCHOR_W-1:0] in_slot;
  anchor_entry_t tbl_entry;
  anchor_entry_t par_upd;
  anchor_entry_t anc_upd;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_slot  = anchor_id[ANCHOR_W-1:0];
  assign sp_dec   = sp - SP_W'(1);

  // entries never written since reset or clear read as zero
  assign tbl_entry = tbl_rd_hit ? tbl_rd_data : '0;

  always_comb begin
    par_upd      = tbl_entry;
    par_upd.excl = tbl_entry.excl - elapsed;
    anc_upd.excl = tbl_entry.excl + elapsed;
    anc_upd.incl = fr_old_incl + elapsed;
    anc_upd.hits = tbl_entry.hits + HITS_W'(1);
  end

  always_comb begin
    state_next  = state;
    tbl_rd      = 1'b0;
    tbl_rd_addr = '0;
    tbl_wr      = 1'b0;
    tbl_wr_addr = '0;
    tbl_wr_data = '0;
    frm_rd      = 1'b0;
    frm_rd_addr = '0;
    frm_wr      = 1'b0;
    frm_wr_addr = '0;
    frm_wr_data = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(func))
            FUNC_BEGIN: begin
              if (sp == SP_W'(STACK_DEPTH)) begin
                state_next = ST_DONE;
              end else begin
                tbl_rd      = 1'b1;
                tbl_rd_addr = in_slot;
                state_next  = ST_BEGIN;
              end
            end
            FUNC_END: begin
              if (sp == '0) begin
                state_next = ST_DONE;
              end else begin
                frm_rd      = 1'b1;
                frm_rd_addr = sp_dec[FIDX_W-1:0];
                state_next  = ST_FRAME;
              end
            end
            FUNC_READ: begin
              tbl_rd      = 1'b1;
              tbl_rd_addr = in_slot;
              state_next  = ST_REPORT;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_BEGIN: begin
        frm_wr               = 1'b1;
        frm_wr_addr          = sp[FIDX_W-1:0];
        frm_wr_data.parent   = cur_parent;
        frm_wr_data.anchor   = op_slot;
        frm_wr_data.old_incl = tbl_entry.incl;
        frm_wr_data.start    = op_ts;
        state_next           = ST_DONE;
      end
      ST_FRAME: begin
        tbl_rd      = 1'b1;
        tbl_rd_addr = frm_rd_data.parent;
        state_next  = ST_PARENT;
      end
      ST_PARENT: begin
        // parent goes first so an anchor nested in itself sees the update
        tbl_wr      = 1'b1;
        tbl_wr_addr = fr_parent;
        tbl_wr_data = par_upd;
        state_next  = ST_ANC_RD;
      end
      ST_ANC_RD: begin
        tbl_rd      = 1'b1;
        tbl_rd_addr = fr_anchor;
        state_next  = ST_ANCHOR;
      end
      ST_ANCHOR: begin
        tbl_wr      = 1'b1;
        tbl_wr_addr = fr_anchor;
        tbl_wr_data = anc_upd;
        state_next  = ST_DONE;
      end
      ST_REPORT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // anchor table memory
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      tbl_mem[tbl_wr_addr] <= tbl_wr_data;
    end
    if (tbl_rd) begin
      tbl_rd_data <= tbl_mem[tbl_rd_addr];
      tbl_rd_hit  <= ent_valid[tbl_rd_addr];
    end
  end

  // call stack memory
  always_ff @(posedge clk) begin
    if (frm_wr) begin
      frm_mem[frm_wr_addr] <= frm_wr_data;
    end
    if (frm_rd) begin
      frm_rd_data <= frm_mem[frm_rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sp         <= '0;
      cur_parent <= '0;
      ent_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && func_t'(func) == FUNC_CLEAR) begin
        ent_valid <= '0;
      end
      if (tbl_wr) begin
        ent_valid[tbl_wr_addr] <= 1'b1;
      end
      if (state == ST_BEGIN) begin
        sp         <= sp + SP_W'(1);
        cur_parent <= op_slot;
      end
      if (state == ST_FRAME) begin
        sp         <= sp_dec;
        cur_parent <= frm_rd_data.parent;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_slot   <= in_slot;
      op_ts     <= timestamp;
      res_entry <= '0;
      if (func_t'(func) == FUNC_BEGIN && sp == SP_W'(STACK_DEPTH)) begin
        res_status <= STATUS_OVERFLOW;
      end else if (func_t'(func) == FUNC_END && sp == '0) begin
        res_status <= STATUS_UNDERFLOW;
      end else begin
        res_status <= STATUS_OK;
      end
    end
    if (state == ST_FRAME) begin
      elapsed     <= op_ts - frm_rd_data.start;
      fr_parent   <= frm_rd_data.parent;
      fr_anchor   <= frm_rd_data.anchor;
      fr_old_incl <= frm_rd_data.old_incl;
    end
    if (state == ST_ANCHOR) begin
      res_entry <= anc_upd;
    end
    if (state == ST_REPORT) begin
      res_entry <= tbl_entry;
    end
    if (state == ST_DONE && out_free) begin
      status          <= res_status;
      exclusive_ticks <= res_entry.excl;
      inclusive_ticks <= res_entry.incl;
      hits            <= res_entry.hits;
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(tbl_wr && tbl_rd && tbl_wr_addr == tbl_rd_addr))
    else $error("anchor table read and write of the same entry in one cycle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result shown without a finished transaction");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_status == STATUS_UNDERFLOW) |-> sp == '0)
    else $error("underflow reported with frames on the stack");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (accept && func_t'(func) == FUNC_CLEAR) |=> ent_valid == '0)
    else $error("clear left anchor entries valid");
`endif

endmodule
